// ===== sv/ptx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ptx_pkg;

  localparam int unsigned COORD_W           = 32;
  localparam int unsigned ANGLE_W           = 18;
  localparam int unsigned MODE_W            = 3;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_W             = 32;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned CORDIC_STAGES_MAX = 32;

  // angle reduction and phase
  localparam int unsigned FULL_TURN   = 92160;
  localparam int unsigned RED_W       = 17;
  localparam int unsigned RECIP       = 93207;
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned DEG_MOD     = 45;
  localparam int unsigned QDEG_W      = 11;
  localparam int unsigned RIDX_W      = 6;
  localparam int unsigned RTAB_W      = 21;
  localparam int unsigned PHASE_W     = QDEG_W + RTAB_W;

  // CORDIC
  localparam int unsigned TRIG_W = 33;
  localparam int unsigned ZW     = 34;
  localparam int unsigned ATAN_W = 30;
  localparam int unsigned GAIN   = 652032874;

  // products and rounding
  localparam int unsigned DIFF_W      = COORD_W + 1;
  localparam int unsigned MAG_TW      = TRIG_W - 1;
  localparam int unsigned PROD_W      = DIFF_W + MAG_TW;
  localparam int unsigned PSHIFT      = 18;
  localparam int unsigned Q28_W       = PROD_W - PSHIFT + 1;
  localparam int unsigned SUM_W       = Q28_W + 1;
  localparam int unsigned ROUND_SHIFT = 12;
  localparam int unsigned ROUND_HALF  = 2048;
  localparam int unsigned ROT_W       = SUM_W - ROUND_SHIFT;
  localparam int unsigned FIN_W       = ROT_W + 1;
  localparam longint unsigned FLUSH   = 64'd70368744;

  // pipeline depth
  localparam int unsigned ANGLE_STAGES = 4;
  localparam int unsigned MUL_STAGES   = 4;
  localparam int unsigned LAT_FIXED    = ANGLE_STAGES + MUL_STAGES + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRANSLATE  = 3'd0,
    MODE_MIRROR_X   = 3'd1,
    MODE_MIRROR_Y   = 3'd2,
    MODE_ROT_ORIGIN = 3'd3,
    MODE_ROT_PIVOT  = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 3'd0,
    REG_SHIFT_X = 3'd1,
    REG_SHIFT_Y = 3'd2,
    REG_ANGLE   = 3'd3,
    REG_PIVOT_X = 3'd4,
    REG_PIVOT_Y = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
  } pt_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
  } pt_out_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [ZW-1:0]     z;
    logic                     flip;
  } cordic_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [DIFF_W-1:0]  px;
    logic signed [DIFF_W-1:0]  py;
  } coord_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] rx;
    logic signed [ROT_W-1:0] ry;
  } rot_t;

  // floor(r * 2^21 / 45) for the remainder r of the reduced angle / 45
  typedef logic [(1 << RIDX_W)-1:0][RTAB_W-1:0] rtab_t;

  function automatic rtab_t build_rtab();
    rtab_t t;
    logic [63:0] v;
    t = '0;
    for (int i = 0; i < DEG_MOD; i++) begin
      v = 64'(i);
      v = (v << RTAB_W) / DEG_MOD;
      t[i] = v[RTAB_W-1:0];
    end
    return t;
  endfunction

  localparam rtab_t RTAB = build_rtab();

  // atan(2^-i) in binary angle, 2^32 per turn
  function automatic logic [ATAN_W-1:0] atan_turn(input int unsigned i);
    logic [ATAN_W-1:0] a;
    case (i)
      0:  a = 30'd536870912;
      1:  a = 30'd316933406;
      2:  a = 30'd167458907;
      3:  a = 30'd85004756;
      4:  a = 30'd42667331;
      5:  a = 30'd21354465;
      6:  a = 30'd10679838;
      7:  a = 30'd5340245;
      8:  a = 30'd2670163;
      9:  a = 30'd1335087;
      10: a = 30'd667544;
      11: a = 30'd333772;
      12: a = 30'd166886;
      13: a = 30'd83443;
      14: a = 30'd41722;
      15: a = 30'd20861;
      16: a = 30'd10430;
      17: a = 30'd5215;
      18: a = 30'd2608;
      19: a = 30'd1304;
      20: a = 30'd652;
      21: a = 30'd326;
      22: a = 30'd163;
      23: a = 30'd81;
      24: a = 30'd41;
      25: a = 30'd20;
      26: a = 30'd10;
      27: a = 30'd5;
      28: a = 30'd3;
      29: a = 30'd1;
      30: a = 30'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== sv/point_transform_2d_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// 2D point transform: translate, mirror, or rotate about the origin or a pivot.
// Fully pipelined: a transaction is taken in every cycle (busy stays low) and
// its result comes out as a one-cycle done_o strobe with out_o; the depth is
// 4 angle stages, one CORDIC stage per iteration, 4 multiply/round stages and
// the output register. There is no output backpressure, so the receiver must
// take every done_o pulse. Write the configuration registers only while no
// transaction is in flight.
module point_transform_2d_unit #(
  parameter int unsigned CORDIC_STAGES = ptx_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire ptx_pkg::pt_in_t                  in_i,
  output logic                                  done_o,
  output ptx_pkg::pt_out_t                      out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ptx_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ptx_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import ptx_pkg::*;

  localparam int unsigned LINE_LEN = ANGLE_STAGES + CORDIC_STAGES + MUL_STAGES;
  localparam int unsigned MUL_TAP  = ANGLE_STAGES + CORDIC_STAGES - 1;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [FIN_W-1:0] v);
    logic [FIN_W-COORD_W:0] hi;
    hi = v[FIN_W-1:COORD_W-1];
    if (hi == '0 || hi == '1) begin
      return v[COORD_W-1:0];
    end
    return v[FIN_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  logic [MODE_W-1:0]         mode_q;
  logic signed [COORD_W-1:0] shift_x_q, shift_y_q, pivot_x_q, pivot_y_q;
  logic signed [ANGLE_W-1:0] angle_q;

  logic                      accept;
  coord_t                    coord_d;
  coord_t                    line_q [LINE_LEN];
  logic [LINE_LEN-1:0]       valid_q;
  cordic_t                   cord [CORDIC_STAGES+1];
  rot_t                      rot;
  coord_t                    last;
  logic signed [FIN_W-1:0]   fx, fy;
  pt_out_t                   out_d, out_q;
  logic                      done_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_W'(MODE_TRANSLATE);
      shift_x_q <= '0;
      shift_y_q <= '0;
      angle_q   <= '0;
      pivot_x_q <= '0;
      pivot_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:    mode_q    <= cfg_wdata_i[MODE_W-1:0];
        REG_SHIFT_X: shift_x_q <= cfg_wdata_i[COORD_W-1:0];
        REG_SHIFT_Y: shift_y_q <= cfg_wdata_i[COORD_W-1:0];
        REG_ANGLE:   angle_q   <= cfg_wdata_i[ANGLE_W-1:0];
        REG_PIVOT_X: pivot_x_q <= cfg_wdata_i[COORD_W-1:0];
        REG_PIVOT_Y: pivot_y_q <= cfg_wdata_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // origin rotation is pivot rotation with a zero pivot
  always_comb begin
    coord_d.x = in_i.in_x;
    coord_d.y = in_i.in_y;
    if (mode_q == MODE_W'(MODE_ROT_PIVOT)) begin
      coord_d.px = DIFF_W'(in_i.in_x) - DIFF_W'(pivot_x_q);
      coord_d.py = DIFF_W'(in_i.in_y) - DIFF_W'(pivot_y_q);
    end else begin
      coord_d.px = DIFF_W'(in_i.in_x);
      coord_d.py = DIFF_W'(in_i.in_y);
    end
  end

  always_ff @(posedge clk_i) begin
    line_q[0] <= coord_d;
    for (int k = 1; k < LINE_LEN; k++) begin
      line_q[k] <= line_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LINE_LEN-2:0], accept};
    end
  end

  ptx_angle u_angle (
    .clk_i   (clk_i),
    .angle_i (angle_q),
    .init_o  (cord[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    ptx_cordic_stage #(
      .STAGE (g)
    ) u_stage (
      .clk_i (clk_i),
      .c_i   (cord[g]),
      .c_o   (cord[g+1])
    );
  end

  ptx_rotmul u_rotmul (
    .clk_i  (clk_i),
    .px_i   (line_q[MUL_TAP].px),
    .py_i   (line_q[MUL_TAP].py),
    .trig_i (cord[CORDIC_STAGES]),
    .rot_o  (rot)
  );

  assign last = line_q[LINE_LEN-1];

  always_comb begin
    fx = FIN_W'(last.x);
    fy = FIN_W'(last.y);
    unique case (mode_e'(mode_q))
      MODE_TRANSLATE: begin
        fx = FIN_W'(last.x) + FIN_W'(shift_x_q);
        fy = FIN_W'(last.y) + FIN_W'(shift_y_q);
      end
      MODE_MIRROR_X: fy = -FIN_W'(last.y);
      MODE_MIRROR_Y: fx = -FIN_W'(last.x);
      MODE_ROT_ORIGIN: begin
        fx = FIN_W'(rot.rx);
        fy = FIN_W'(rot.ry);
      end
      MODE_ROT_PIVOT: begin
        fx = FIN_W'(rot.rx) + FIN_W'(pivot_x_q);
        fy = FIN_W'(rot.ry) + FIN_W'(pivot_y_q);
      end
      default: ;
    endcase
    out_d.out_x = sat(fx);
    out_d.out_y = sat(fy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      out_q  <= '0;
    end else begin
      done_q <= valid_q[LINE_LEN-1];
      if (valid_q[LINE_LEN-1]) begin
        out_q <= out_d;
      end
    end
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule
`default_nettype wire

// ===== sv/ptx_angle.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptx_angle (
  input  wire logic                                clk_i,
  input  wire logic signed [ptx_pkg::ANGLE_W-1:0] angle_i,
  output ptx_pkg::cordic_t                         init_o
);
  import ptx_pkg::*;

  localparam int unsigned TW = RED_W + 2;
  localparam int unsigned MW = RED_W + RECIP_W;

  logic signed [TW:0]    t_s;
  logic [TW-1:0]         tu;
  logic [RED_W-1:0]      a_d, a_q, a2_q;
  logic [MW-1:0]         m_q;
  logic [QDEG_W-1:0]     q_d, q_q;
  logic [RED_W-1:0]      rem;
  logic [RIDX_W-1:0]     r_q;
  logic [PHASE_W-1:0]    phase, phase_f;
  logic                  flip;
  cordic_t               init_d, init_q;

  // modulo one turn: bias positive, then take off whole turns
  always_comb begin
    t_s = (TW + 1)'(angle_i) + (TW + 1)'(2 * FULL_TURN);
    tu  = t_s[TW-1:0];
    if (tu >= TW'(3 * FULL_TURN)) begin
      a_d = RED_W'(tu - TW'(3 * FULL_TURN));
    end else if (tu >= TW'(2 * FULL_TURN)) begin
      a_d = RED_W'(tu - TW'(2 * FULL_TURN));
    end else if (tu >= TW'(FULL_TURN)) begin
      a_d = RED_W'(tu - TW'(FULL_TURN));
    end else begin
      a_d = RED_W'(tu);
    end
  end

  // a / 45 by reciprocal, exact over the reduced range
  always_comb begin
    q_d = m_q[RECIP_SHIFT+QDEG_W-1:RECIP_SHIFT];
    rem = a2_q - RED_W'(RED_W'(q_d) * RED_W'(DEG_MOD));
  end

  always_comb begin
    phase   = {q_q, RTAB_W'(0)} | PHASE_W'(RTAB[r_q]);
    flip    = phase[PHASE_W-1] ^ phase[PHASE_W-2];
    phase_f = {phase[PHASE_W-1] ^ flip, phase[PHASE_W-2:0]};
    init_d.x    = TRIG_W'(GAIN);
    init_d.y    = '0;
    init_d.z    = ZW'(signed'(phase_f));
    init_d.flip = flip;
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    a2_q   <= a_q;
    m_q    <= MW'(a_q) * MW'(RECIP);
    q_q    <= q_d;
    r_q    <= rem[RIDX_W-1:0];
    init_q <= init_d;
  end

  assign init_o = init_q;

endmodule
`default_nettype wire

// ===== sv/ptx_cordic_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptx_cordic_stage #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic             clk_i,
  input  wire ptx_pkg::cordic_t c_i,
  output ptx_pkg::cordic_t      c_o
);
  import ptx_pkg::*;

  localparam logic [ATAN_W-1:0] ATAN = atan_turn(STAGE);

  logic signed [TRIG_W-1:0] xi, yi, dx, dy;
  logic signed [ZW-1:0]     zi;
  cordic_t                  c_d, c_q;

  always_comb begin
    xi  = c_i.x;
    yi  = c_i.y;
    zi  = c_i.z;
    dx  = yi >>> STAGE;
    dy  = xi >>> STAGE;
    c_d = c_i;
    if (!zi[ZW-1]) begin
      c_d.x = xi - dx;
      c_d.y = yi + dy;
      c_d.z = zi - ZW'(ATAN);
    end else begin
      c_d.x = xi + dx;
      c_d.y = yi - dy;
      c_d.z = zi + ZW'(ATAN);
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  assign c_o = c_q;

endmodule
`default_nettype wire

// ===== sv/ptx_rotmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptx_rotmul (
  input  wire logic                               clk_i,
  input  wire logic signed [ptx_pkg::DIFF_W-1:0] px_i,
  input  wire logic signed [ptx_pkg::DIFF_W-1:0] py_i,
  input  wire ptx_pkg::cordic_t                   trig_i,
  output ptx_pkg::rot_t                           rot_o
);
  import ptx_pkg::*;

  function automatic logic signed [Q28_W-1:0] scale(input logic [PROD_W-1:0] p,
                                                    input logic neg);
    logic [Q28_W-1:0] m;
    m = (p <= PROD_W'(FLUSH)) ? '0 : Q28_W'(p >> PSHIFT);
    return neg ? -m : m;
  endfunction

  logic signed [TRIG_W-1:0] cx, sy;
  logic [DIFF_W-1:0]        mpx_q, mpy_q;
  logic [MAG_TW-1:0]        mc_q, ms_q;
  logic                     npx_q, npy_q, nc_q, ns_q;
  logic [PROD_W-1:0]        xc_q, ys_q, yc_q, xs_q;
  logic                     nxc_q, nys_q, nyc_q, nxs_q;
  logic signed [Q28_W-1:0]  vxc_q, vys_q, vyc_q, vxs_q;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  rot_t                     rot_d, rot_q;

  assign cx = trig_i.x;
  assign sy = trig_i.y;

  always_comb begin
    sum_x = SUM_W'(vxc_q) - SUM_W'(vys_q) + SUM_W'(ROUND_HALF);
    sum_y = SUM_W'(vyc_q) + SUM_W'(vxs_q) + SUM_W'(ROUND_HALF);
    rot_d.rx = ROT_W'(sum_x >>> ROUND_SHIFT);
    rot_d.ry = ROT_W'(sum_y >>> ROUND_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    // sign and magnitude; a half-turn fold flips the trig signs
    mpx_q <= px_i[DIFF_W-1] ? DIFF_W'(-px_i) : DIFF_W'(px_i);
    mpy_q <= py_i[DIFF_W-1] ? DIFF_W'(-py_i) : DIFF_W'(py_i);
    mc_q  <= cx[TRIG_W-1] ? MAG_TW'(-cx) : MAG_TW'(cx);
    ms_q  <= sy[TRIG_W-1] ? MAG_TW'(-sy) : MAG_TW'(sy);
    npx_q <= px_i[DIFF_W-1];
    npy_q <= py_i[DIFF_W-1];
    nc_q  <= cx[TRIG_W-1] ^ trig_i.flip;
    ns_q  <= sy[TRIG_W-1] ^ trig_i.flip;

    xc_q  <= PROD_W'(mpx_q) * PROD_W'(mc_q);
    ys_q  <= PROD_W'(mpy_q) * PROD_W'(ms_q);
    yc_q  <= PROD_W'(mpy_q) * PROD_W'(mc_q);
    xs_q  <= PROD_W'(mpx_q) * PROD_W'(ms_q);
    nxc_q <= npx_q ^ nc_q;
    nys_q <= npy_q ^ ns_q;
    nyc_q <= npy_q ^ nc_q;
    nxs_q <= npx_q ^ ns_q;

    vxc_q <= scale(xc_q, nxc_q);
    vys_q <= scale(ys_q, nys_q);
    vyc_q <= scale(yc_q, nyc_q);
    vxs_q <= scale(xs_q, nxs_q);

    rot_q <= rot_d;
  end

  assign rot_o = rot_q;

endmodule
`default_nettype wire

// ===== sv/ptx_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptx_checker #(
  parameter int unsigned CORDIC_STAGES = ptx_pkg::CORDIC_STAGES_DEF
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done_i,
  input wire ptx_pkg::pt_out_t out_i
);
  import ptx_pkg::*;

  localparam int unsigned LATENCY = CORDIC_STAGES + LAT_FIXED;

  a_done_has_transaction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(start && !busy, LATENCY))
    else $error("result without a matching transaction");

  a_transaction_gets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_i)
    else $error("transaction lost");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("pipeline refused a transaction");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_i |-> $stable(out_i))
    else $error("result changed without strobe");

endmodule

bind point_transform_2d_unit ptx_checker #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_ptx_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_i (done_o),
  .out_i  (out_o)
);
`default_nettype wire

// ===== sim/point_transform_2d_unit_checker.sv =====
`timescale 1ns / 1ps
module point_transform_2d_unit_checker #(
  parameter int unsigned CORDIC_STAGES = ptx_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  ptx_pkg::pt_in_t               pt_in_i,
  input  logic                          done_i,
  input  ptx_pkg::pt_out_t              pt_out_i,
  input  logic                          cfg_we_i,
  input  logic [ptx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ptx_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int                            pending_o,
  output int                            checked_o,
  output int                            errors_o
);
  import ptx_pkg::*;

  localparam longint TURN_Q8    = 92160;
  localparam longint GAIN_Q30   = 652032874;
  localparam longint COORD_HI   = 64'sd2147483647;
  localparam longint COORD_LO   = -64'sd2147483648;
  localparam longint unsigned FLUSH_Q46 = 64'd70368744;

  longint arctan_turn [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  logic [MODE_W-1:0] mode_q;
  longint shift_x_q, shift_y_q, angle_q, pivot_x_q, pivot_y_q;

  pt_out_t expected_vertices [$];
  int      results_checked;
  int      mismatch_count;

  // Q16.16 times Q1.30, flushed when tiny, truncated to Q.28
  function automatic longint scale_q28(longint c, longint t);
    longint unsigned mag_c, mag_t, full;
    bit neg;
    neg   = (c < 0) != (t < 0);
    mag_c = (c < 0) ? -c : c;
    mag_t = (t < 0) ? -t : t;
    full  = mag_c * mag_t;
    if (full <= FLUSH_Q46) return 0;
    return neg ? -longint'(full >> 18) : longint'(full >> 18);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic void rotate_about(input longint px, input longint py,
                                       output longint rx, output longint ry);
    longint ang, phase, cs, sn, zc, dx, dy;
    bit flip;
    ang = angle_q % TURN_Q8;
    if (ang < 0) ang += TURN_Q8;
    phase = (ang << 32) / TURN_Q8;
    flip  = 1'b0;
    if ((phase >>> 30) == 1 || (phase >>> 30) == 2) begin
      phase = (phase - (64'sd1 <<< 31)) & 64'h0000_0000_FFFF_FFFF;
      flip  = 1'b1;
    end
    zc = longint'(signed'(phase[31:0]));
    cs = GAIN_Q30;
    sn = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = sn >>> i;
      dy = cs >>> i;
      if (zc >= 0) begin
        cs -= dx;
        sn += dy;
        zc -= arctan_turn[i];
      end else begin
        cs += dx;
        sn -= dy;
        zc += arctan_turn[i];
      end
    end
    if (flip) begin
      cs = -cs;
      sn = -sn;
    end
    rx = (scale_q28(px, cs) - scale_q28(py, sn) + 2048) >>> 12;
    ry = (scale_q28(py, cs) + scale_q28(px, sn) + 2048) >>> 12;
  endfunction

  function automatic pt_out_t transform_vertex(pt_in_t p);
    longint px, py, ox, oy;
    pt_out_t r;
    px = longint'(signed'(p.in_x));
    py = longint'(signed'(p.in_y));
    ox = px;
    oy = py;
    case (mode_q)
      MODE_TRANSLATE: begin
        ox = px + shift_x_q;
        oy = py + shift_y_q;
      end
      MODE_MIRROR_X:   oy = -py;
      MODE_MIRROR_Y:   ox = -px;
      MODE_ROT_ORIGIN: rotate_about(px, py, ox, oy);
      MODE_ROT_PIVOT: begin
        rotate_about(px - pivot_x_q, py - pivot_y_q, ox, oy);
        ox += pivot_x_q;
        oy += pivot_y_q;
      end
      default: ;
    endcase
    r.out_x = COORD_W'(clamp_coord(ox));
    r.out_y = COORD_W'(clamp_coord(oy));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pt_out_t want;
    if (!rst_ni) begin
      mode_q    = '0;
      shift_x_q = 0;
      shift_y_q = 0;
      angle_q   = 0;
      pivot_x_q = 0;
      pivot_y_q = 0;
      expected_vertices.delete();
      results_checked = 0;
      mismatch_count  = 0;
    end else begin
      if (done_i) begin
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d", $time,
                   pt_out_i.out_x, pt_out_i.out_y);
          mismatch_count++;
        end else begin
          want = expected_vertices.pop_front();
          if (pt_out_i.out_x !== want.out_x) begin
            $display("%0t: out_x mismatch: expected %0d, got %0d", $time,
                     want.out_x, pt_out_i.out_x);
            mismatch_count++;
          end
          if (pt_out_i.out_y !== want.out_y) begin
            $display("%0t: out_y mismatch: expected %0d, got %0d", $time,
                     want.out_y, pt_out_i.out_y);
            mismatch_count++;
          end
          results_checked++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:    mode_q    = cfg_wdata_i[MODE_W-1:0];
          REG_SHIFT_X: shift_x_q = longint'(signed'(cfg_wdata_i));
          REG_SHIFT_Y: shift_y_q = longint'(signed'(cfg_wdata_i));
          REG_ANGLE:   angle_q   = longint'(signed'(cfg_wdata_i[ANGLE_W-1:0]));
          REG_PIVOT_X: pivot_x_q = longint'(signed'(cfg_wdata_i));
          REG_PIVOT_Y: pivot_y_q = longint'(signed'(cfg_wdata_i));
          default: ;
        endcase
      end
      if (start_i && !busy_i) expected_vertices.push_back(transform_vertex(pt_in_i));
    end
    pending_o <= expected_vertices.size();
    checked_o <= results_checked;
    errors_o  <= mismatch_count;
  end

endmodule

// ===== sim/point_transform_2d_unit_tb.sv =====
`timescale 1ns / 1ps
module point_transform_2d_unit_tb;
  import ptx_pkg::*;

  localparam int unsigned STAGES  = CORDIC_STAGES_DEF;
  localparam int LATENCY          = STAGES + LAT_FIXED;
  localparam int STALL_LIMIT      = 1000;
  localparam int RANDOM_PHASES    = 20;
  localparam int POINTS_PER_PHASE = 54;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  pt_in_t               pt_in     = '0;
  logic                 done;
  pt_out_t              pt_out;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int pending, checked, errors;
  int points_sent     = 0;
  int settings_loaded = 0;
  int idle_cycles     = 0;

  point_transform_2d_unit #(.CORDIC_STAGES(STAGES)) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .in_i       (pt_in),
    .done_o     (done),
    .out_o      (pt_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  point_transform_2d_unit_checker #(.CORDIC_STAGES(STAGES)) vertex_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_i     (busy),
    .pt_in_i    (pt_in),
    .done_i     (done),
    .pt_out_i   (pt_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pending_o  (pending),
    .checked_o  (checked),
    .errors_o   (errors)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_point(input pt_in_t p);
    @(negedge clk);
    start <= 1'b1;
    pt_in <= p;
    do @(posedge clk); while (busy);
    points_sent++;
  endtask

  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    start     <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_config(input logic [MODE_W-1:0] mode,
                             input logic [31:0] sx, input logic [31:0] sy,
                             input logic [ANGLE_W-1:0] ang,
                             input logic [31:0] pvx, input logic [31:0] pvy);
    write_reg(REG_MODE, CFG_W'(mode));
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_ANGLE, {{(CFG_W-ANGLE_W){ang[ANGLE_W-1]}}, ang});
    write_reg(REG_PIVOT_X, pvx);
    write_reg(REG_PIVOT_Y, pvy);
    settings_loaded++;
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = '0;
          3: v = '1;
          default: v = 32'd1;
        endcase
      end
      1, 2: v = $urandom_range(0, 511) - 32'd256;
      3:    v = $urandom_range(0, 1 << 21) - 32'd1048576;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_angle();
    logic [31:0] a;
    case ($urandom_range(0, 3))
      0: a = $urandom_range(0, 8) * 32'd23040 - 32'd92160;
      1: a = $urandom_range(0, (1 << ANGLE_W) - 1);
      2: a = $urandom_range(0, 184320) - 32'd92160;
      default: a = $urandom_range(0, 15) - 32'd8;
    endcase
    return a[ANGLE_W-1:0];
  endfunction

  initial begin
    logic [MODE_W-1:0] mode;
    bit idle_on;
    bit leftover;
    leftover = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // translate, saturating both ways
    load_config(MODE_TRANSLATE, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0);
    send_point({32'h7FFF_FFFF, 32'h8000_0000});
    send_point({32'h8000_0000, 32'h7FFF_FFFF});
    send_point({32'h0000_0001, 32'hFFFF_FFFF});
    wait_drained();
    load_config(MODE_MIRROR_X, '0, '0, '0, '0, '0);
    send_point({32'd5, 32'h8000_0000});
    send_point({32'd0, 32'd0});
    send_point({32'hFFFF_FFFF, 32'h7FFF_FFFF});
    wait_drained();
    load_config(MODE_MIRROR_Y, '0, '0, '0, '0, '0);
    send_point({32'h8000_0000, 32'd7});
    send_point({32'd0, 32'd0});
    wait_drained();
    load_config(MODE_ROT_ORIGIN, '0, '0, '0, '0, '0);
    send_point({32'h7FFF_FFFF, 32'h8000_0000});
    send_point({32'd1, 32'hFFFF_FFFF});
    wait_drained();
    load_config(MODE_ROT_ORIGIN, '0, '0, 18'd23040, '0, '0);
    send_point({32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_point({32'h0001_0000, 32'd0});
    wait_drained();
    load_config(MODE_ROT_ORIGIN, '0, '0, 18'd46080, '0, '0);
    send_point({32'h1234_5678, 32'hFFFF_FFFB});
    wait_drained();
    load_config(MODE_ROT_ORIGIN, '0, '0, -18'sd92160, '0, '0);
    send_point({32'h0001_0000, 32'h0001_0000});
    wait_drained();
    load_config(MODE_ROT_ORIGIN, '0, '0, 18'd92160, '0, '0);
    send_point({32'h0001_0000, 32'h0001_0000});
    wait_drained();
    // angles beyond a full turn
    load_config(MODE_ROT_ORIGIN, '0, '0, 18'h1FFFF, '0, '0);
    send_point({32'h0003_8000, 32'hFFF0_0000});
    wait_drained();
    load_config(MODE_ROT_ORIGIN, '0, '0, 18'h20000, '0, '0);
    send_point({32'h0003_8000, 32'hFFF0_0000});
    wait_drained();
    // pivot far from the vertex: difference needs the extra bit
    load_config(MODE_ROT_PIVOT, '0, '0, 18'd46080, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point({32'h7FFF_FFFF, 32'h8000_0000});
    send_point({32'h8000_0000, 32'h7FFF_FFFF});
    wait_drained();
    for (int m = 5; m < 8; m++) begin
      load_config(MODE_W'(m), 32'h0001_0000, 32'h0001_0000, 18'd23040,
                  32'h0002_0000, 32'h0002_0000);
      send_point({32'hDEAD_BEEF, 32'h0BAD_F00D});
      wait_drained();
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(0, 9) == 0) mode = $urandom_range(5, 7);
      else mode = $urandom_range(0, 4);
      load_config(mode, rand_coord(), rand_coord(), rand_angle(),
                  rand_coord(), rand_coord());
      idle_on = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < POINTS_PER_PHASE; k++) begin
        if (idle_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 7));
        else if (k == POINTS_PER_PHASE / 2 && ph % 5 == 2) wait_drained();
        send_point({rand_coord(), rand_coord()});
      end
      wait_drained();
    end

    repeat (LATENCY + 5) @(posedge clk);
    if (pending != 0) begin
      $display("%0t: %0d results never arrived", $time, pending);
      leftover = 1'b1;
    end
    $display("Sent %0d vertices under %0d register settings, all modes incl. undefined",
             points_sent, settings_loaded);
    $display("Compared %0d transformed vertices, %0d field mismatches", checked, errors);
    if (errors == 0 && !leftover) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ptx_pkg.sv
sv/ptx_angle.sv
sv/ptx_cordic_stage.sv
sv/ptx_rotmul.sv
sv/point_transform_2d_unit.sv
sv/ptx_checker.sv
sim/point_transform_2d_unit_checker.sv
sim/point_transform_2d_unit_tb.sv
